// ===== sv/rotation_matrix_to_quaternion_defines.svh =====
// Assertion macros for the rotation matrix to quaternion block.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/rmq_pkg.sv =====
// Package: widths and types for the rotation matrix to quaternion block.
package rmq_pkg;
  localparam int DataWidth = 24;
  localparam int FracBits  = 22;
  // square root argument fits in 27 bits unsigned; shifted by FracBits
  localparam int ArgWidth  = DataWidth + 3;
  localparam int RadWidth  = 2 * ((ArgWidth + FracBits + 1) / 2);
  localparam int RootWidth = RadWidth / 2;
  localparam int NumWidth  = DataWidth + 1;
  localparam int DivWidth  = RootWidth + 1;
  localparam int QuoSteps  = NumWidth + FracBits;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic signed [NumWidth-1:0]  num_t;
endpackage

// ===== sv/rotation_matrix_to_quaternion.sv =====
// Top level: stream wrapper around the conversion pipeline.
// A matrix enters in every cycle while the pipeline advances; the result
// passes through root bits + quotient bits + 1 register stages, set by the
// bit-per-stage square root and the three divide lanes.
// The whole pipeline holds while the output item waits and tready is low.
`include "rotation_matrix_to_quaternion_defines.svh"
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // r00 r10 r20 r01 r11 r21 r02 r12 r22, lowest first
  input  logic [9*DataWidth-1:0] s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // quat_w quat_x quat_y quat_z, lowest first
  output logic [4*DataWidth-1:0] m_tdata,
  // branch_taken
  output logic [1:0]             m_tuser
);
  logic    advance;
  data_t   m [9];
  data_t   q [4];
  branch_t br;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  for (genvar i = 0; i < 9; i++) begin : g_in
    assign m[i] = s_tdata[i*DataWidth +: DataWidth];
  end
  assign m_tdata = {q[3], q[2], q[1], q[0]};
  assign m_tuser = br;

  rmq_core u_core (
    .clk, .rst, .advance,
    .in_valid (s_tvalid),
    .m,
    .out_valid(m_tvalid),
    .q,
    .br_out   (br)
  );

  `ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ASSERT_IMPL(a_ready, clk, rst, !m_tvalid, s_tready)
endmodule

// ===== sv/rmq_core.sv =====
// Pipelined datapath: branch select, bit-serial square root stages, divide stages.
module rmq_core import rmq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        in_valid,
  input  data_t       m [9],
  output logic        out_valid,
  output data_t       q [4],
  output branch_t     br_out
);
  localparam int DepthS = RootWidth;
  localparam int DepthD = QuoSteps;
  localparam int QWidth = DataWidth + 2;

  // stage 0: branch, argument, numerators
  logic [ArgWidth-1:0] arg0;
  num_t                n0 [3];
  branch_t             br0;
  logic                v0;

  always_comb begin
    logic signed [DataWidth+2:0] a00, a11, a22, one, tr, ar;
    a00 = (DataWidth+3)'(m[0]);
    a11 = (DataWidth+3)'(m[4]);
    a22 = (DataWidth+3)'(m[8]);
    one = (DataWidth+3)'(1) <<< FracBits;
    tr  = a00 + a11 + a22;
    if (tr > 0) begin
      br0 = BR_TRACE; ar = tr + one;
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      br0 = BR_X; ar = one + a00 - a11 - a22;
    end else if (m[4] > m[8]) begin
      br0 = BR_Y; ar = one + a11 - a00 - a22;
    end else begin
      br0 = BR_Z; ar = one + a22 - a00 - a11;
    end
    arg0 = ar[DataWidth+2] ? '0 : ArgWidth'(ar);
  end

  // m order: r00 r10 r20 r01 r11 r21 r02 r12 r22
  function automatic num_t sx(data_t v);
    return NumWidth'(v);
  endfunction

  always_comb begin
    num_t t21_12, t02_20, t10_01, s01_10, s02_20, s12_21;
    t21_12 = sx(m[5]) - sx(m[7]);
    t02_20 = sx(m[6]) - sx(m[2]);
    t10_01 = sx(m[1]) - sx(m[3]);
    s01_10 = sx(m[3]) + sx(m[1]);
    s02_20 = sx(m[6]) + sx(m[2]);
    s12_21 = sx(m[7]) + sx(m[5]);
    unique case (br0)
      BR_TRACE: begin n0[0] = t21_12; n0[1] = t02_20; n0[2] = t10_01; end
      BR_X:     begin n0[0] = t21_12; n0[1] = s01_10; n0[2] = s02_20; end
      BR_Y:     begin n0[0] = t02_20; n0[1] = s01_10; n0[2] = s12_21; end
      default:  begin n0[0] = t10_01; n0[1] = s02_20; n0[2] = s12_21; end
    endcase
  end
  assign v0 = in_valid;

  // square root: one result bit per stage
  logic [RadWidth-1:0]   srad [DepthS+1];
  logic [RootWidth+1:0]  srem [DepthS+1];
  logic [RootWidth-1:0]  sroot[DepthS+1];
  num_t                  sn   [DepthS+1][3];
  branch_t               sbr  [DepthS+1];
  logic                  sv   [DepthS+1];

  assign srad[0]  = RadWidth'(arg0) << FracBits;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sn[0]    = n0;
  assign sbr[0]   = br0;
  assign sv[0]    = v0;

  for (genvar s = 0; s < DepthS; s++) begin : g_sqrt
    logic [RootWidth+1:0] rem_n, trial;
    always_comb begin
      rem_n = {srem[s][RootWidth-1:0], srad[s][RadWidth-1 -: 2]};
      trial = {sroot[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) sv[s+1] <= 1'b0;
      else if (advance) sv[s+1] <= sv[s];
      if (advance) begin
        srad[s+1] <= srad[s] << 2;
        sn[s+1]   <= sn[s];
        sbr[s+1]  <= sbr[s];
        if (rem_n >= trial) begin
          srem[s+1]  <= rem_n - trial;
          sroot[s+1] <= {sroot[s][RootWidth-2:0], 1'b1};
        end else begin
          srem[s+1]  <= rem_n;
          sroot[s+1] <= {sroot[s][RootWidth-2:0], 1'b0};
        end
      end
    end
  end

  // restoring division, three lanes, one quotient bit per stage
  logic [DivWidth-1:0]  dd   [DepthD+1];
  logic [RootWidth-1:0] droot[DepthD+1];
  branch_t              dbr  [DepthD+1];
  logic                 dv   [DepthD+1];
  logic [QuoSteps-1:0]  dnum [DepthD+1][3];
  logic [DivWidth:0]    drem [DepthD+1][3];
  logic [QWidth-1:0]    dq   [DepthD+1][3];
  logic                 dneg [DepthD+1][3];
  logic                 dzero[DepthD+1][3];

  assign dd[0]    = {sroot[DepthS], 1'b0};
  assign droot[0] = sroot[DepthS];
  assign dbr[0]   = sbr[DepthS];
  assign dv[0]    = sv[DepthS];
  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [NumWidth-1:0] mag;
    assign mag = sn[DepthS][l][NumWidth-1] ? NumWidth'(-sn[DepthS][l])
                                           : NumWidth'(sn[DepthS][l]);
    assign dnum[0][l]  = QuoSteps'(mag) << FracBits;
    assign drem[0][l]  = '0;
    assign dq[0][l]    = '0;
    assign dneg[0][l]  = sn[DepthS][l][NumWidth-1];
    assign dzero[0][l] = sn[DepthS][l] == '0;
  end

  localparam logic [QWidth-1:0] Cap = QWidth'(1) << DataWidth;
  for (genvar s = 0; s < DepthD; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) dv[s+1] <= 1'b0;
      else if (advance) dv[s+1] <= dv[s];
      if (advance) begin
        dd[s+1]    <= dd[s];
        droot[s+1] <= droot[s];
        dbr[s+1]   <= dbr[s];
      end
    end
    for (genvar l = 0; l < 3; l++) begin : g_l
      logic [DivWidth:0]   r;
      logic                b;
      logic [QWidth:0]     qn;
      always_comb begin
        r  = {drem[s][l][DivWidth-1:0], dnum[s][l][QuoSteps-1]};
        b  = r >= (DivWidth+1)'(dd[s]);
        qn = {dq[s][l], b};
      end
      always_ff @(posedge clk) begin
        if (advance) begin
          dnum[s+1][l]  <= dnum[s][l] << 1;
          drem[s+1][l]  <= b ? r - (DivWidth+1)'(dd[s]) : r;
          dq[s+1][l]    <= (qn > (QWidth+1)'(Cap)) ? Cap : QWidth'(qn);
          dneg[s+1][l]  <= dneg[s][l];
          dzero[s+1][l] <= dzero[s][l];
        end
      end
    end
  end

  // output assembly
  localparam data_t SMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam data_t SMin = {1'b1, {(DataWidth-1){1'b0}}};
  data_t lane_q [3];
  data_t half;
  for (genvar l = 0; l < 3; l++) begin : g_fin
    always_comb begin
      if (dzero[DepthD][l]) lane_q[l] = '0;
      else if (dd[DepthD] == '0) lane_q[l] = dneg[DepthD][l] ? SMin : SMax;
      else if (dneg[DepthD][l])
        lane_q[l] = (dq[DepthD][l] >= QWidth'(SMax) + 1'b1) ? SMin
                    : DataWidth'(-dq[DepthD][l]);
      else
        lane_q[l] = (dq[DepthD][l] > QWidth'(SMax)) ? SMax : DataWidth'(dq[DepthD][l]);
    end
  end
  assign half = DataWidth'(droot[DepthD] >> 1);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= dv[DepthD];
    if (advance) begin
      br_out <= dbr[DepthD];
      unique case (dbr[DepthD])
        BR_TRACE: begin q[0] <= half; q[1] <= lane_q[0]; q[2] <= lane_q[1];
                        q[3] <= lane_q[2]; end
        BR_X:     begin q[0] <= lane_q[0]; q[1] <= half; q[2] <= lane_q[1];
                        q[3] <= lane_q[2]; end
        BR_Y:     begin q[0] <= lane_q[0]; q[1] <= lane_q[1]; q[2] <= half;
                        q[3] <= lane_q[2]; end
        default:  begin q[0] <= lane_q[0]; q[1] <= lane_q[1]; q[2] <= lane_q[2];
                        q[3] <= half; end
      endcase
    end
  end
endmodule
